>>> rtl/bmhq_pkg.sv
// Shared types and constants for the binary max-heap queue.
// Used by binary_max_heap_queue; no dependencies of its own.
package bmhq_pkg;

  localparam int KEY_W        = 32;
  localparam int KIND_W       = 2;
  localparam int POS_W        = 6;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_CHANGE  = 2'd2,
    KIND_DELETE  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OLD_W,
    S_DEL_W,
    S_DEL_LAST,
    S_LAST_W,
    S_UP,
    S_UP_W,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_RESULT
  } state_t;

endpackage

>>> rtl/binary_max_heap_queue.sv
// Binary max-heap priority queue of signed 32-bit keys.
// Input channel (in_valid/in_stall): one request word with kind, value and
// position. Kinds: insert, extract max, change key at a slot, delete a slot.
// Result channel (out_valid/out_stall): one word per request with the removed
// key, the new maximum, the key count and a status (ok, empty, full, bad slot).
// Keys live in one RAM with a registered read; the moving key is held in a
// register and parents or children are shifted into the hole until it settles.
// An error goes straight to the result; an insert starts sift-up at once, other
// requests mostly first read the old or last key. Each sift-up level reads the
// parent; each sift-down level reads the left, then the right child (only the left
// for a single child, none at a leaf), all through the single RAM read port.
// One request is in flight at a time; in_stall is high while it is worked on.
// A finished result sits in the output register; the next request is accepted
// while it waits, and only the final hand-off waits on out_stall.
// Reset (rst_n low, synchronous) empties the heap and drops any pending result;
// RAM contents are not cleared since only slots below the count are read.
module binary_max_heap_queue #(
  parameter int CAPACITY = bmhq_pkg::CAPACITY_DEF,
  localparam int IDX_W   = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bmhq_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [bmhq_pkg::KEY_W-1:0]   in_value,
  input  logic [bmhq_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bmhq_pkg::KEY_W-1:0]   out_removed_value,
  output logic signed [bmhq_pkg::KEY_W-1:0]   out_top_value,
  output logic [CNT_W-1:0]                    out_count,
  output logic [bmhq_pkg::STATUS_W-1:0]       out_status
);

  localparam int KEY_W = bmhq_pkg::KEY_W;
  localparam int CMP_W = (CNT_W > bmhq_pkg::POS_W) ? CNT_W : bmhq_pkg::POS_W;

  bmhq_pkg::state_t  state_r, state_nxt;
  bmhq_pkg::status_t status_r, status_nxt;
  bmhq_pkg::status_t acc_status;
  bmhq_pkg::kind_t   in_kind_e;

  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] lval_r, lval_nxt;
  logic signed [KEY_W-1:0] removed_r, removed_nxt;
  logic signed [KEY_W-1:0] top_r;
  logic [IDX_W-1:0]        hole_r, hole_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0] out_removed_r, out_top_r;
  logic [CNT_W-1:0]        out_count_r;
  logic [bmhq_pkg::STATUS_W-1:0] out_status_r;
  logic                    out_load;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr, mem_raddr;
  logic signed [KEY_W-1:0] mem_wdata;
  logic [KEY_W-1:0]        mem_rdata_raw;
  logic signed [KEY_W-1:0] rdata;

  logic                    in_fire;
  logic [CMP_W-1:0]        pos_ext;
  logic [IDX_W-1:0]        pos_idx;
  logic [IDX_W-1:0]        parent;
  logic [IDX_W:0]          lchild, rchild, cnt_ext;
  logic                    l_in, r_in;
  logic                    up_gt, l_gt, r_gt, dn_move;
  logic signed [KEY_W-1:0] cur_big;
  logic [IDX_W:0]          big_idx;
  logic signed [KEY_W-1:0] big_val;
  logic                    last_is_pos;

  bmhq_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_heap_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata_raw)
  );

  assign rdata     = mem_rdata_raw;
  assign in_stall  = (state_r != bmhq_pkg::S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign in_kind_e = bmhq_pkg::kind_t'(in_kind);
  assign pos_ext   = CMP_W'(in_position);
  assign pos_idx   = IDX_W'(pos_ext);

  assign parent  = IDX_W'((hole_r - 1'b1) >> 1);
  assign lchild  = {hole_r, 1'b1};
  assign rchild  = lchild + 1'b1;
  assign cnt_ext = (IDX_W + 1)'(cnt_r);
  assign l_in    = lchild < cnt_ext;
  assign r_in    = rchild < cnt_ext;

  assign up_gt   = key_r > rdata;
  assign l_gt    = lval_r > key_r;
  assign cur_big = l_gt ? lval_r : key_r;
  assign r_gt    = rdata > cur_big;
  assign dn_move = l_gt || r_gt;
  assign big_idx = r_gt ? rchild : lchild;
  assign big_val = r_gt ? rdata : lval_r;

  assign last_is_pos = (CNT_W'(hole_r) == (cnt_r - 1'b1));

  // request check at accept; empty takes priority over the slot check
  always_comb begin
    acc_status = bmhq_pkg::ST_OK;
    if (in_kind_e == bmhq_pkg::KIND_INSERT) begin
      if (cnt_r == CNT_W'(CAPACITY)) begin
        acc_status = bmhq_pkg::ST_FULL;
      end
    end else if (cnt_r == '0) begin
      acc_status = bmhq_pkg::ST_EMPTY;
    end else if (in_kind_e != bmhq_pkg::KIND_EXTRACT && pos_ext >= CMP_W'(cnt_r)) begin
      acc_status = bmhq_pkg::ST_BADPOS;
    end
  end

  assign out_load = (state_r == bmhq_pkg::S_RESULT) && (!out_valid_r || !out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmhq_pkg::S_IDLE: begin
        if (in_fire) begin
          if (acc_status != bmhq_pkg::ST_OK) begin
            state_nxt = bmhq_pkg::S_RESULT;
          end else begin
            case (in_kind_e)
              bmhq_pkg::KIND_INSERT:  state_nxt = bmhq_pkg::S_UP;
              bmhq_pkg::KIND_EXTRACT: state_nxt = (cnt_r == CNT_W'(1)) ?
                                                  bmhq_pkg::S_RESULT : bmhq_pkg::S_LAST_W;
              bmhq_pkg::KIND_CHANGE:  state_nxt = bmhq_pkg::S_OLD_W;
              bmhq_pkg::KIND_DELETE:  state_nxt = bmhq_pkg::S_DEL_W;
              default:                state_nxt = bmhq_pkg::S_RESULT;
            endcase
          end
        end
      end
      bmhq_pkg::S_OLD_W:    state_nxt = up_gt ? bmhq_pkg::S_UP : bmhq_pkg::S_DN;
      bmhq_pkg::S_DEL_W:    state_nxt = last_is_pos ? bmhq_pkg::S_RESULT : bmhq_pkg::S_DEL_LAST;
      bmhq_pkg::S_DEL_LAST: state_nxt = (rdata > removed_r) ? bmhq_pkg::S_UP : bmhq_pkg::S_DN;
      bmhq_pkg::S_LAST_W:   state_nxt = bmhq_pkg::S_DN;
      bmhq_pkg::S_UP:       state_nxt = (hole_r == '0) ? bmhq_pkg::S_RESULT : bmhq_pkg::S_UP_W;
      bmhq_pkg::S_UP_W:     state_nxt = up_gt ? bmhq_pkg::S_UP : bmhq_pkg::S_RESULT;
      bmhq_pkg::S_DN:       state_nxt = l_in ? bmhq_pkg::S_DN_L : bmhq_pkg::S_RESULT;
      bmhq_pkg::S_DN_L: begin
        if (r_in) begin
          state_nxt = bmhq_pkg::S_DN_R;
        end else begin
          state_nxt = (rdata > key_r) ? bmhq_pkg::S_DN : bmhq_pkg::S_RESULT;
        end
      end
      bmhq_pkg::S_DN_R:     state_nxt = dn_move ? bmhq_pkg::S_DN : bmhq_pkg::S_RESULT;
      bmhq_pkg::S_RESULT:   state_nxt = out_load ? bmhq_pkg::S_IDLE : bmhq_pkg::S_RESULT;
      default:              state_nxt = bmhq_pkg::S_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    key_nxt     = key_r;
    lval_nxt    = lval_r;
    removed_nxt = removed_r;
    hole_nxt    = hole_r;
    cnt_nxt     = cnt_r;
    status_nxt  = status_r;
    mem_we      = 1'b0;
    mem_waddr   = hole_r;
    mem_wdata   = key_r;
    mem_raddr   = parent;
    case (state_r)
      bmhq_pkg::S_IDLE: begin
        mem_raddr = pos_idx;
        if (in_fire) begin
          status_nxt  = acc_status;
          removed_nxt = '0;
          key_nxt     = in_value;
          hole_nxt    = pos_idx;
          if (acc_status == bmhq_pkg::ST_OK) begin
            case (in_kind_e)
              bmhq_pkg::KIND_INSERT: begin
                hole_nxt = IDX_W'(cnt_r);
                cnt_nxt  = cnt_r + 1'b1;
              end
              bmhq_pkg::KIND_EXTRACT: begin
                removed_nxt = top_r;
                cnt_nxt     = cnt_r - 1'b1;
                hole_nxt    = '0;
                mem_raddr   = IDX_W'(cnt_r - 1'b1);
              end
              default: begin
              end
            endcase
          end
        end
      end
      bmhq_pkg::S_OLD_W: begin
      end
      bmhq_pkg::S_DEL_W: begin
        removed_nxt = rdata;
        cnt_nxt     = cnt_r - 1'b1;
        mem_raddr   = IDX_W'(cnt_r - 1'b1);
      end
      bmhq_pkg::S_DEL_LAST: begin
        key_nxt = rdata;
      end
      bmhq_pkg::S_LAST_W: begin
        key_nxt = rdata;
      end
      bmhq_pkg::S_UP: begin
        // root reached: settle the key there
        if (hole_r == '0) begin
          mem_we = 1'b1;
        end
      end
      bmhq_pkg::S_UP_W: begin
        mem_we = 1'b1;
        if (up_gt) begin
          mem_wdata = rdata;
          hole_nxt  = parent;
        end
      end
      bmhq_pkg::S_DN: begin
        mem_raddr = IDX_W'(lchild);
        if (!l_in) begin
          mem_we = 1'b1;
        end
      end
      bmhq_pkg::S_DN_L: begin
        lval_nxt  = rdata;
        mem_raddr = IDX_W'(rchild);
        if (!r_in) begin
          mem_we = 1'b1;
          if (rdata > key_r) begin
            mem_wdata = rdata;
            hole_nxt  = IDX_W'(lchild);
          end
        end
      end
      bmhq_pkg::S_DN_R: begin
        mem_we = 1'b1;
        if (dn_move) begin
          mem_wdata = big_val;
          hole_nxt  = IDX_W'(big_idx);
        end
      end
      bmhq_pkg::S_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmhq_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= key_nxt;
    lval_r    <= lval_nxt;
    removed_r <= removed_nxt;
    hole_r    <= hole_nxt;
    status_r  <= status_nxt;
    // mirror slot 0 so the maximum is at hand without a read
    if (mem_we && mem_waddr == '0) begin
      top_r <= mem_wdata;
    end
    if (out_load) begin
      out_removed_r <= removed_r;
      out_top_r     <= (cnt_r != '0) ? top_r : '0;
      out_count_r   <= cnt_r;
      out_status_r  <= status_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_top_value     = out_top_r;
  assign out_count         = out_count_r;
  assign out_status        = out_status_r;

endmodule

>>> rtl/bmhq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
